// ===== hdl/cia_pkg.sv =====
package cia_pkg;

    // opcodes
    localparam logic [3:0] OP_EQ  = 4'd0;
    localparam logic [3:0] OP_NE  = 4'd1;
    localparam logic [3:0] OP_LT  = 4'd2;
    localparam logic [3:0] OP_GT  = 4'd3;
    localparam logic [3:0] OP_LE  = 4'd4;
    localparam logic [3:0] OP_GE  = 4'd5;
    localparam logic [3:0] OP_ADD = 4'd6;
    localparam logic [3:0] OP_SUB = 4'd7;
    localparam logic [3:0] OP_MUL = 4'd8;
    localparam logic [3:0] OP_DIV = 4'd9;
    localparam logic [3:0] OP_MOD = 4'd10;
    localparam logic [3:0] OP_AND = 4'd11;
    localparam logic [3:0] OP_OR  = 4'd12;
    localparam logic [3:0] OP_XOR = 4'd13;
    localparam logic [3:0] OP_SHL = 4'd14;
    localparam logic [3:0] OP_SHR = 4'd15;

    // result type codes
    localparam logic [3:0] RT_I8  = 4'd0;
    localparam logic [3:0] RT_I16 = 4'd1;
    localparam logic [3:0] RT_I32 = 4'd2;
    localparam logic [3:0] RT_I64 = 4'd3;
    localparam logic [3:0] RT_U8  = 4'd4;
    localparam logic [3:0] RT_U16 = 4'd5;
    localparam logic [3:0] RT_U32 = 4'd6;
    localparam logic [3:0] RT_U64 = 4'd7;

    // status codes
    localparam logic [1:0] ST_INT  = 2'd0;
    localparam logic [1:0] ST_BOOL = 2'd1;
    localparam logic [1:0] ST_UNK  = 2'd2;

    localparam int DIV_STAGES = 64;

    localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
    localparam logic [63:0] I64_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;

    // side information that travels with an item through the divider
    typedef struct packed {
        logic [3:0]  op;
        logic [3:0]  rtype;
        logic        sign_a;
        logic        sign_q;
        logic        ok;
        logic        bval;
        logic [63:0] res;
    } t_tag;

    // lower bound of a result type
    function automatic logic [63:0] type_lo(input logic [3:0] rt);
        logic [63:0] v;
        unique case (rt)
            RT_I8:   v = 64'hFFFF_FFFF_FFFF_FF80;
            RT_I16:  v = 64'hFFFF_FFFF_FFFF_8000;
            RT_I32:  v = 64'hFFFF_FFFF_8000_0000;
            RT_I64:  v = SIGN_BIT;
            default: v = 64'd0;
        endcase
        return v;
    endfunction

    // upper bound of a result type
    function automatic logic [63:0] type_hi(input logic [3:0] rt);
        logic [63:0] v;
        unique case (rt)
            RT_I8:   v = 64'd127;
            RT_I16:  v = 64'd32767;
            RT_I32:  v = 64'd2147483647;
            RT_U8:   v = 64'd255;
            RT_U16:  v = 64'd65535;
            RT_U32:  v = 64'd4294967295;
            default: v = I64_MAX;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/cia_div_pipe.sv =====
module cia_div_pipe (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [63:0]      i_dvd,
    input  logic [63:0]      i_dvs,
    input  cia_pkg::t_tag    i_tag,
    output logic             o_valid,
    output logic [63:0]      o_quo,
    output logic [63:0]      o_rem,
    output cia_pkg::t_tag    o_tag
);
    import cia_pkg::*;

    logic [DIV_STAGES-1:0] r_vld;
    logic [63:0]           r_rem [DIV_STAGES];
    logic [63:0]           r_dvd [DIV_STAGES];
    logic [63:0]           r_dvs [DIV_STAGES];
    t_tag                  r_tag [DIV_STAGES];

    // one quotient bit per stage, restoring
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic        w_vld;
        logic [63:0] w_rem;
        logic [63:0] w_dvd;
        logic [63:0] w_dvs;
        t_tag        w_tag;
        logic [64:0] w_trial;
        logic [64:0] w_diff;

        if (k == 0) begin : g_first
            assign w_vld = i_valid;
            assign w_rem = 64'd0;
            assign w_dvd = i_dvd;
            assign w_dvs = i_dvs;
            assign w_tag = i_tag;
        end else begin : g_next
            assign w_vld = r_vld[k-1];
            assign w_rem = r_rem[k-1];
            assign w_dvd = r_dvd[k-1];
            assign w_dvs = r_dvs[k-1];
            assign w_tag = r_tag[k-1];
        end

        assign w_trial = {w_rem, w_dvd[63]};
        assign w_diff  = w_trial - {1'b0, w_dvs};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= w_diff[64] ? w_trial[63:0] : w_diff[63:0];
            r_dvd[k] <= {w_dvd[62:0], ~w_diff[64]};
            r_dvs[k] <= w_dvs;
            r_tag[k] <= w_tag;
        end
    end

    assign o_valid = r_vld[DIV_STAGES-1];
    assign o_quo   = r_dvd[DIV_STAGES-1];
    assign o_rem   = r_rem[DIV_STAGES-1];
    assign o_tag   = r_tag[DIV_STAGES-1];

endmodule

// ===== hdl/checked_integer_alu.sv =====
// Overflow-checked 64-bit integer ALU. An item is taken at each rising edge
// with start high and busy low; busy is high only during reset and the cycle
// after it, so a new item may follow every cycle. Each item gives exactly one
// result, marked by o_valid for one cycle, in transfer order. Every item
// passes through the 64-stage restoring divider (one quotient bit per
// stage), after the input, operand prep and split 32x32 multiplier stages.
// The receiver cannot stall the block: results must be taken in the cycle
// they appear.
module checked_integer_alu (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [3:0]         i_action,
    input  logic signed [63:0] i_operand_a,
    input  logic signed [63:0] i_operand_b,
    input  logic [3:0]         i_result_type,
    output logic               o_valid,
    output logic [1:0]         o_status,
    output logic signed [63:0] o_int_value,
    output logic               o_bool_value
);
    import cia_pkg::*;

    logic r_busy;

    // busy during reset and in the cycle after it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end
    assign busy = r_busy;

    // stage 1: input register
    logic        r1_vld;
    logic [3:0]  r1_op;
    logic [3:0]  r1_rt;
    logic [63:0] r1_a;
    logic [63:0] r1_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= start && !r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_op <= i_action;
        r1_rt <= i_result_type;
        r1_a  <= i_operand_a;
        r1_b  <= i_operand_b;
    end

    // stage 2: compares, add/sub, logic, shifts, magnitudes
    logic        n2_bool;
    logic [63:0] n2_res;
    logic        n2_ok;
    logic [63:0] n2_sum;
    logic [63:0] n2_dif;
    logic        n2_lt;
    logic        n2_gt;
    logic        n2_cnt_ok;

    assign n2_sum    = r1_a + r1_b;
    assign n2_dif    = r1_a - r1_b;
    assign n2_lt     = $signed(r1_a) < $signed(r1_b);
    assign n2_gt     = $signed(r1_b) < $signed(r1_a);
    assign n2_cnt_ok = (r1_b[63:6] == 58'd0);

    always_comb begin
        n2_bool = 1'b0;
        n2_res  = 64'd0;
        n2_ok   = 1'b1;
        unique case (r1_op)
            OP_EQ:  n2_bool = (r1_a == r1_b);
            OP_NE:  n2_bool = (r1_a != r1_b);
            OP_LT:  n2_bool = n2_lt;
            OP_GT:  n2_bool = n2_gt;
            OP_LE:  n2_bool = !n2_gt;
            OP_GE:  n2_bool = !n2_lt;
            OP_ADD: begin
                n2_res = n2_sum;
                n2_ok  = !((r1_a[63] ^ n2_sum[63]) & (r1_b[63] ^ n2_sum[63]));
            end
            OP_SUB: begin
                n2_res = n2_dif;
                n2_ok  = !((r1_a[63] ^ r1_b[63]) & (r1_a[63] ^ n2_dif[63]));
            end
            OP_MUL: n2_ok = 1'b1;
            OP_DIV, OP_MOD: begin
                n2_ok = (r1_b != 64'd0) && !((r1_a == SIGN_BIT) && (r1_b == '1));
            end
            OP_AND: n2_res = r1_a & r1_b;
            OP_OR:  n2_res = r1_a | r1_b;
            OP_XOR: n2_res = r1_a ^ r1_b;
            OP_SHL: begin
                n2_res = r1_a << r1_b[5:0];
                n2_ok  = n2_cnt_ok;
            end
            OP_SHR: begin
                n2_res = $unsigned($signed(r1_a) >>> r1_b[5:0]);
                n2_ok  = n2_cnt_ok;
            end
            default: n2_ok = 1'b0;
        endcase
    end

    logic        r2_vld;
    logic [3:0]  r2_op;
    logic [3:0]  r2_rt;
    logic        r2_bool;
    logic [63:0] r2_res;
    logic        r2_ok;
    logic [63:0] r2_ma;
    logic [63:0] r2_mb;
    logic        r2_sa;
    logic        r2_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_op   <= r1_op;
        r2_rt   <= r1_rt;
        r2_bool <= n2_bool;
        r2_res  <= n2_res;
        r2_ok   <= n2_ok;
        r2_ma   <= r1_a[63] ? 64'd0 - r1_a : r1_a;
        r2_mb   <= r1_b[63] ? 64'd0 - r1_b : r1_b;
        r2_sa   <= r1_a[63];
        r2_sq   <= r1_a[63] ^ r1_b[63];
    end

    // stage 3: four 32x32 partial products
    logic        r3_vld;
    t_tag        r3_tag;
    logic [63:0] r3_ma;
    logic [63:0] r3_mb;
    logic [63:0] r3_ll;
    logic [63:0] r3_lh;
    logic [63:0] r3_hl;
    logic [63:0] r3_hh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_tag <= '{op: r2_op, rtype: r2_rt, sign_a: r2_sa, sign_q: r2_sq,
                    ok: r2_ok, bval: r2_bool, res: r2_res};
        r3_ma  <= r2_ma;
        r3_mb  <= r2_mb;
        r3_ll  <= 64'(r2_ma[31:0])  * 64'(r2_mb[31:0]);
        r3_lh  <= 64'(r2_ma[31:0])  * 64'(r2_mb[63:32]);
        r3_hl  <= 64'(r2_ma[63:32]) * 64'(r2_mb[31:0]);
        r3_hh  <= 64'(r2_ma[63:32]) * 64'(r2_mb[63:32]);
    end

    // stage 4: sum the partial products
    logic          r4_vld;
    t_tag          r4_tag;
    logic [63:0]   r4_ma;
    logic [63:0]   r4_mb;
    logic          r4_hi_nz;
    logic [63:0]   r4_lo;
    logic [127:0]  n4_prod;

    assign n4_prod = {r3_hh, r3_ll} + {32'd0, r3_lh, 32'd0} + {32'd0, r3_hl, 32'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_tag   <= r3_tag;
        r4_ma    <= r3_ma;
        r4_mb    <= r3_mb;
        r4_hi_nz <= (n4_prod[127:64] != 64'd0);
        r4_lo    <= n4_prod[63:0];
    end

    // stage 5: multiply sign and overflow check
    logic        r5_vld;
    t_tag        r5_tag;
    logic [63:0] r5_ma;
    logic [63:0] r5_mb;
    t_tag        n5_tag;

    always_comb begin
        n5_tag = r4_tag;
        if (r4_tag.op == OP_MUL) begin
            n5_tag.ok  = !r4_hi_nz &&
                         (r4_tag.sign_q ? (r4_lo <= SIGN_BIT) : (r4_lo <= I64_MAX));
            n5_tag.res = r4_tag.sign_q ? 64'd0 - r4_lo : r4_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_tag <= n5_tag;
        r5_ma  <= r4_ma;
        r5_mb  <= r4_mb;
    end

    // divider stages
    logic        d_vld;
    logic [63:0] d_quo;
    logic [63:0] d_rem;
    t_tag        d_tag;

    cia_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r5_vld),
        .i_dvd   (r5_ma),
        .i_dvs   (r5_mb),
        .i_tag   (r5_tag),
        .o_valid (d_vld),
        .o_quo   (d_quo),
        .o_rem   (d_rem),
        .o_tag   (d_tag)
    );

    // final stage: divide sign fix, type range check, output register
    logic [63:0] n6_res;
    logic        n6_fit;
    logic [1:0]  n6_status;

    always_comb begin
        if (d_tag.op == OP_DIV) begin
            n6_res = d_tag.sign_q ? 64'd0 - d_quo : d_quo;
        end else if (d_tag.op == OP_MOD) begin
            n6_res = d_tag.sign_a ? 64'd0 - d_rem : d_rem;
        end else begin
            n6_res = d_tag.res;
        end
        n6_fit = !d_tag.rtype[3] &&
                 !($signed(n6_res) < $signed(type_lo(d_tag.rtype))) &&
                 !($signed(type_hi(d_tag.rtype)) < $signed(n6_res));
        if (d_tag.op <= OP_GE) begin
            n6_status = ST_BOOL;
        end else if (d_tag.ok && n6_fit) begin
            n6_status = ST_INT;
        end else begin
            n6_status = ST_UNK;
        end
    end

    logic        r_valid;
    logic [1:0]  r_status;
    logic [63:0] r_int;
    logic        r_bool;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n6_status;
        r_int    <= (n6_status == ST_INT) ? n6_res : 64'd0;
        r_bool   <= (n6_status == ST_BOOL) ? d_tag.bval : 1'b0;
    end

    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_int_value  = r_int;
    assign o_bool_value = r_bool;

    // output consistency checks
    a_unk_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_UNK |-> o_int_value == 64'd0 && !o_bool_value)
        else $error("unknown result carries a value");

    a_bool_no_int: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_BOOL |-> o_int_value == 64'd0)
        else $error("boolean result carries an integer");

    a_int_no_bool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_INT |-> !o_bool_value)
        else $error("integer result carries a boolean");

endmodule
